@@ hdl/mcrd_pkg.sv @@
// ----------------------------------------------------------------------------
// mcrd_pkg
// Types, constants and tables shared by the motor controller response decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mcrd_pkg;

    localparam int NTC_POINTS  = 28;
    localparam int NTC_SEG_W   = $clog2(NTC_POINTS - 1);
    localparam int CODE_W      = 16;
    localparam int NUM_W       = 16;
    localparam int DEN_W       = 10;
    localparam int Q_W         = 6;
    localparam int TENTHS_W    = 11;
    localparam int MAIN_W      = 23;
    localparam int SECOND_W    = 9;
    localparam int SCALE_W     = 22;
    localparam int PROD_W      = 38;
    localparam int ROUND_SHIFT = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    localparam logic [SCALE_W-1:0] VOLT_RECIP  = 22'd118896;
    localparam logic [SCALE_W-1:0] CURR_SCALE  = 22'd2449945;
    localparam logic [PROD_W-1:0]  ROUND_HALF  = 38'd32768;
    localparam logic [CODE_W-1:0]  RAW_INVALID = 16'hFFFF;
    localparam logic [3:0]         LEN_MIN     = 4'd3;

    localparam logic [CODE_W-1:0] NTC_CODE [NTC_POINTS] = '{
        16'd16245, 16'd16308, 16'd16387, 16'd16487, 16'd16609, 16'd16759, 16'd16938,
        16'd17151, 16'd17400, 16'd17688, 16'd18017, 16'd18387, 16'd18797, 16'd19247,
        16'd19733, 16'd20250, 16'd20793, 16'd21357, 16'd21933, 16'd22515, 16'd23097,
        16'd23671, 16'd24232, 16'd24775, 16'd25296, 16'd25792, 16'd26261, 16'd26702
    };

    // temperatures in 0.1 degC
    localparam logic signed [TENTHS_W-1:0] NTC_TENTHS [NTC_POINTS] = '{
        -11'sd350, -11'sd300, -11'sd250, -11'sd200, -11'sd150, -11'sd100, -11'sd50,
        11'sd0,    11'sd50,   11'sd100,  11'sd150,  11'sd200,  11'sd250,  11'sd300,
        11'sd350,  11'sd400,  11'sd450,  11'sd500,  11'sd550,  11'sd600,  11'sd650,
        11'sd700,  11'sd750,  11'sd800,  11'sd850,  11'sd900,  11'sd950,  11'sd1000
    };

    typedef enum logic [2:0] {
        KIND_IGNORED,
        KIND_MOTOR_TEMP,
        KIND_CTRL_TEMP,
        KIND_VOLTAGE,
        KIND_CURRENT,
        KIND_CURRENT_INVALID,
        KIND_UNKNOWN
    } kind_t;

    typedef enum logic [2:0] {
        CFG_RESPONSE_ID,
        CFG_REG_MOTOR_TEMP,
        CFG_REG_CTRL_TEMP,
        CFG_REG_DC_VOLTAGE,
        CFG_REG_DC_CURRENT,
        CFG_SECOND_OFFSET
    } cfg_index_t;

    typedef struct packed {
        logic [10:0] response_id;
        logic [7:0]  reg_motor_temp;
        logic [7:0]  reg_controller_temp;
        logic [7:0]  reg_dc_voltage;
        logic [7:0]  reg_dc_current;
        logic [7:0]  second_sensor_offset;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        response_id:          11'd385,
        reg_motor_temp:       8'd73,
        reg_controller_temp:  8'd74,
        reg_dc_voltage:       8'd235,
        reg_dc_current:       8'd32,
        second_sensor_offset: 8'd80
    };

    typedef struct packed {
        logic [10:0] frame_id;
        logic [3:0]  frame_length;
        logic [7:0]  register_byte;
        logic [7:0]  value_low_byte;
        logic [7:0]  value_high_byte;
    } frame_t;

    typedef struct packed {
        kind_t                     kind;
        logic [7:0]                reg_seen;
        logic [SECOND_W-1:0]       second;
        logic signed [MAIN_W-1:0]  main;
        logic [CODE_W-1:0]         raw;
        logic                      interp;
        logic [NTC_SEG_W-1:0]      seg;
    } s1_t;

    typedef struct packed {
        kind_t                       kind;
        logic [7:0]                  reg_seen;
        logic [SECOND_W-1:0]         second;
        logic signed [MAIN_W-1:0]    main;
        logic                        interp;
        logic [NUM_W-1:0]            rem;
        logic [DEN_W-1:0]            den;
        logic signed [TENTHS_W-1:0]  base;
        logic [PROD_W-1:0]           prod;
    } s2_t;

    typedef struct packed {
        kind_t                       kind;
        logic [7:0]                  reg_seen;
        logic [SECOND_W-1:0]         second;
        logic signed [MAIN_W-1:0]    main;
        logic                        interp;
        logic [NUM_W-1:0]            rem;
        logic [DEN_W-1:0]            den;
        logic signed [TENTHS_W-1:0]  base;
        logic [Q_W/2-1:0]            q_hi;
    } s3_t;

    typedef struct packed {
        kind_t                     kind;
        logic [7:0]                reg_seen;
        logic [SECOND_W-1:0]       second;
        logic signed [MAIN_W-1:0]  main;
    } result_t;

    typedef struct packed {
        logic             q;
        logic [NUM_W-1:0] rem;
    } div_t;

    // one restoring division step against den shifted left by shift
    function automatic div_t div_step(input logic [NUM_W-1:0] rem,
                                      input logic [DEN_W-1:0] den,
                                      input int shift);
        logic [NUM_W-1:0] dsh;
        div_t             res;
        dsh = NUM_W'(den) << shift;
        if (rem >= dsh)
        begin
            res.q   = 1'b1;
            res.rem = rem - dsh;
        end
        else
        begin
            res.q   = 1'b0;
            res.rem = rem;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hdl/mcrd_decode.sv @@
// ----------------------------------------------------------------------------
// mcrd_decode
// Stage 1: frame filter, register select, simple readings, NTC segment search.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrd_decode (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mcrd_pkg::cfg_t  cfg,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire mcrd_pkg::frame_t frame,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output mcrd_pkg::s1_t        out_data
);

    logic           valid_reg;
    mcrd_pkg::s1_t  data_reg;
    mcrd_pkg::s1_t  data_next;
    logic [mcrd_pkg::CODE_W-1:0] raw;
    logic           match;

    assign raw   = {frame.value_high_byte, frame.value_low_byte};
    assign match = (frame.frame_id == cfg.response_id) &&
                   (frame.frame_length >= mcrd_pkg::LEN_MIN);

    always_comb
    begin
        data_next        = '0;
        data_next.kind   = mcrd_pkg::KIND_IGNORED;
        data_next.raw    = raw;
        for (int j = 0; j < mcrd_pkg::NTC_POINTS - 1; j++)
        begin
            if (mcrd_pkg::NTC_CODE[j] < raw)
                data_next.seg = mcrd_pkg::NTC_SEG_W'(j);
        end
        if (match)
        begin
            data_next.reg_seen = frame.register_byte;
            if (frame.register_byte == cfg.reg_motor_temp)
            begin
                data_next.kind   = mcrd_pkg::KIND_MOTOR_TEMP;
                data_next.main   = $signed(mcrd_pkg::MAIN_W'(frame.value_low_byte));
                data_next.second = {1'b0, frame.value_low_byte} +
                                   {1'b0, cfg.second_sensor_offset};
            end
            else if (frame.register_byte == cfg.reg_controller_temp)
            begin
                data_next.kind = mcrd_pkg::KIND_CTRL_TEMP;
                if (raw <= mcrd_pkg::NTC_CODE[0])
                    data_next.main = mcrd_pkg::MAIN_W'(mcrd_pkg::NTC_TENTHS[0]);
                else if (raw >= mcrd_pkg::NTC_CODE[mcrd_pkg::NTC_POINTS-1])
                    data_next.main =
                        mcrd_pkg::MAIN_W'(mcrd_pkg::NTC_TENTHS[mcrd_pkg::NTC_POINTS-1]);
                else
                    data_next.interp = 1'b1;
            end
            else if (frame.register_byte == cfg.reg_dc_voltage)
            begin
                data_next.kind = mcrd_pkg::KIND_VOLTAGE;
            end
            else if (frame.register_byte == cfg.reg_dc_current)
            begin
                if (raw == mcrd_pkg::RAW_INVALID)
                begin
                    data_next.kind = mcrd_pkg::KIND_CURRENT_INVALID;
                    data_next.main = $signed(mcrd_pkg::MAIN_W'(raw));
                end
                else
                    data_next.kind = mcrd_pkg::KIND_CURRENT;
            end
            else
            begin
                data_next.kind = mcrd_pkg::KIND_UNKNOWN;
                data_next.main = $signed(mcrd_pkg::MAIN_W'(raw));
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

@@ hdl/mcrd_scale.sv @@
// ----------------------------------------------------------------------------
// mcrd_scale
// Stage 2: scaling multiply and NTC interpolation numerator and divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrd_scale (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire mcrd_pkg::s1_t  in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output mcrd_pkg::s2_t       out_data
);

    logic           valid_reg;
    mcrd_pkg::s2_t  data_reg;
    mcrd_pkg::s2_t  data_next;
    logic [mcrd_pkg::NTC_SEG_W-1:0] seg_up;
    logic [mcrd_pkg::CODE_W-1:0]    code_lo;
    logic [mcrd_pkg::CODE_W-1:0]    span;
    logic [mcrd_pkg::CODE_W-1:0]    offs;
    logic [mcrd_pkg::TENTHS_W-1:0]  step;
    logic [mcrd_pkg::CODE_W+mcrd_pkg::Q_W-1:0] num_wide;
    logic [mcrd_pkg::SCALE_W-1:0]   scale;

    assign seg_up   = in_data.seg + mcrd_pkg::NTC_SEG_W'(1);
    assign code_lo  = mcrd_pkg::NTC_CODE[in_data.seg];
    assign span     = mcrd_pkg::NTC_CODE[seg_up] - code_lo;
    assign offs     = in_data.raw - code_lo;
    assign step     = mcrd_pkg::NTC_TENTHS[seg_up] - mcrd_pkg::NTC_TENTHS[in_data.seg];
    assign num_wide = (mcrd_pkg::CODE_W+mcrd_pkg::Q_W)'(offs) *
                      (mcrd_pkg::CODE_W+mcrd_pkg::Q_W)'(step[mcrd_pkg::Q_W-1:0]);
    assign scale    = (in_data.kind == mcrd_pkg::KIND_VOLTAGE) ? mcrd_pkg::VOLT_RECIP
                                                                : mcrd_pkg::CURR_SCALE;

    always_comb
    begin
        data_next.kind     = in_data.kind;
        data_next.reg_seen = in_data.reg_seen;
        data_next.second   = in_data.second;
        data_next.main     = in_data.main;
        data_next.interp   = in_data.interp;
        data_next.rem      = num_wide[mcrd_pkg::NUM_W-1:0];
        data_next.den      = span[mcrd_pkg::DEN_W-1:0];
        data_next.base     = mcrd_pkg::NTC_TENTHS[in_data.seg];
        data_next.prod     = mcrd_pkg::PROD_W'(in_data.raw) * mcrd_pkg::PROD_W'(scale);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

@@ hdl/mcrd_div.sv @@
// ----------------------------------------------------------------------------
// mcrd_div
// Stage 3: rounding of scaled readings, upper quotient bits of interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrd_div (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire mcrd_pkg::s2_t  in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output mcrd_pkg::s3_t       out_data
);

    logic           valid_reg;
    mcrd_pkg::s3_t  data_reg;
    mcrd_pkg::s3_t  data_next;
    logic [mcrd_pkg::PROD_W-1:0] rounded;

    assign rounded = in_data.prod + mcrd_pkg::ROUND_HALF;

    always_comb
    begin
        mcrd_pkg::div_t st;
        st.q               = 1'b0;
        st.rem             = in_data.rem;
        data_next.kind     = in_data.kind;
        data_next.reg_seen = in_data.reg_seen;
        data_next.second   = in_data.second;
        data_next.interp   = in_data.interp;
        data_next.den      = in_data.den;
        data_next.base     = in_data.base;
        data_next.q_hi     = '0;
        if (in_data.kind == mcrd_pkg::KIND_VOLTAGE || in_data.kind == mcrd_pkg::KIND_CURRENT)
            data_next.main =
                $signed(mcrd_pkg::MAIN_W'(rounded[mcrd_pkg::PROD_W-1:mcrd_pkg::ROUND_SHIFT]));
        else
            data_next.main = in_data.main;
        for (int b = mcrd_pkg::Q_W - 1; b >= mcrd_pkg::Q_W / 2; b--)
        begin
            st = mcrd_pkg::div_step(st.rem, in_data.den, b);
            data_next.q_hi[b - mcrd_pkg::Q_W / 2] = st.q;
        end
        data_next.rem = st.rem;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

@@ hdl/mcrd_out.sv @@
// ----------------------------------------------------------------------------
// mcrd_out
// Stage 4: lower quotient bits, interpolated temperature, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrd_out (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire mcrd_pkg::s3_t  in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output mcrd_pkg::result_t   out_data
);

    logic               valid_reg;
    mcrd_pkg::result_t  data_reg;
    mcrd_pkg::result_t  data_next;
    logic [mcrd_pkg::Q_W-1:0] quot;

    always_comb
    begin
        mcrd_pkg::div_t st;
        st.q = 1'b0;
        st.rem = in_data.rem;
        quot = {in_data.q_hi, {(mcrd_pkg::Q_W / 2){1'b0}}};
        for (int b = mcrd_pkg::Q_W / 2 - 1; b >= 0; b--)
        begin
            st = mcrd_pkg::div_step(st.rem, in_data.den, b);
            quot[b] = st.q;
        end
        data_next.kind     = in_data.kind;
        data_next.reg_seen = in_data.reg_seen;
        data_next.second   = in_data.second;
        if (in_data.interp)
            data_next.main = mcrd_pkg::MAIN_W'(in_data.base) +
                             $signed(mcrd_pkg::MAIN_W'(quot));
        else
            data_next.main = in_data.main;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

@@ hdl/motor_controller_response_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// motor_controller_response_decoder_unit
// Decodes motor controller CAN response frames into scaled readings.
//
// Takes one frame beat per clock while m_tready is high and returns one result
// beat per frame, in order. The four register stages are: frame filter and
// register select, the scaling multiplier, and two halves of a six-step
// restoring divider that interpolates the controller NTC table. Every stage
// holds its beat under back-pressure and accepts a new one as soon as its own
// register frees, so throughput is one beat per cycle while m_tready is high.
// Configuration writes are taken in any cycle and act on frames accepted after.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_controller_response_decoder_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [2:0]                        cfg_index,
    input  wire logic [10:0]                       cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // frame_id, frame_length, register_byte, value_low_byte, value_high_byte
    input  wire logic [mcrd_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // reading_kind, main_value, second_value, register_seen
    output logic [mcrd_pkg::OUT_TDATA_W-1:0]       m_tdata
);

    mcrd_pkg::cfg_t     cfg_reg;
    mcrd_pkg::frame_t   frame;
    mcrd_pkg::s1_t      s1_data;
    mcrd_pkg::s2_t      s2_data;
    mcrd_pkg::s3_t      s3_data;
    mcrd_pkg::result_t  res;
    logic s1_valid, s1_ready, s2_valid, s2_ready, s3_valid, s3_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= mcrd_pkg::CFG_RESET;
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mcrd_pkg::CFG_RESPONSE_ID:    cfg_reg.response_id          <= cfg_data;
                mcrd_pkg::CFG_REG_MOTOR_TEMP: cfg_reg.reg_motor_temp       <= cfg_data[7:0];
                mcrd_pkg::CFG_REG_CTRL_TEMP:  cfg_reg.reg_controller_temp  <= cfg_data[7:0];
                mcrd_pkg::CFG_REG_DC_VOLTAGE: cfg_reg.reg_dc_voltage       <= cfg_data[7:0];
                mcrd_pkg::CFG_REG_DC_CURRENT: cfg_reg.reg_dc_current       <= cfg_data[7:0];
                mcrd_pkg::CFG_SECOND_OFFSET:  cfg_reg.second_sensor_offset <= cfg_data[7:0];
                default:                      cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign frame.frame_id        = s_tdata[10:0];
    assign frame.frame_length    = s_tdata[14:11];
    assign frame.register_byte   = s_tdata[22:15];
    assign frame.value_low_byte  = s_tdata[30:23];
    assign frame.value_high_byte = s_tdata[38:31];

    mcrd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .frame     (frame),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    mcrd_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    mcrd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    mcrd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid),
        .in_ready  (s3_ready),
        .in_data   (s3_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {5'b0, res.reg_seen, res.second, res.main, res.kind};

endmodule

`default_nettype wire

@@ hdl/mcrd_checker.sv @@
// ----------------------------------------------------------------------------
// mcrd_checker
// Port-level checks of the response decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrd_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [mcrd_pkg::OUT_TDATA_W-1:0] m_tdata
);

    logic [2:0]  kind;
    logic [22:0] main_value;
    logic [8:0]  second_value;
    logic [7:0]  register_seen;

    assign kind          = m_tdata[2:0];
    assign main_value    = m_tdata[25:3];
    assign second_value  = m_tdata[34:26];
    assign register_seen = m_tdata[42:35];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled while output side can drain");

    a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && kind == mcrd_pkg::KIND_IGNORED |->
            main_value == '0 && second_value == '0 && register_seen == '0)
        else $error("rejected frame carries data");

    a_second_motor_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && kind != mcrd_pkg::KIND_MOTOR_TEMP |-> second_value == '0)
        else $error("second value set on a non motor reading");

    a_invalid_current: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && kind == mcrd_pkg::KIND_CURRENT_INVALID |-> main_value == 23'd65535)
        else $error("invalid current reading not raw all-ones");

endmodule

bind motor_controller_response_decoder_unit mcrd_checker u_mcrd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
